FILE: design/dns_query_name_extractor_unit_macros.svh
// Assertion macros for the DNS query name extractor.
// Included by the top level; no other dependencies.
`ifndef DNS_QUERY_NAME_EXTRACTOR_UNIT_MACROS_SVH
`define DNS_QUERY_NAME_EXTRACTOR_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define DQNE_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define DQNE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/dqne_pkg.sv
// Shared types and constants for the DNS query name extractor.
// No dependencies.
package dqne_pkg;

    localparam int unsigned HEADER_BYTES = 12;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STATUS_IGNORED      = 2'd0;
    localparam logic [1:0] STATUS_INCOMPATIBLE = 2'd1;
    localparam logic [1:0] STATUS_PROCESSED    = 2'd2;

    localparam logic [1:0] REG_WANTED_CLASS  = 2'd0;
    localparam logic [1:0] REG_WANTED_TYPE_1 = 2'd1;
    localparam logic [1:0] REG_WANTED_TYPE_2 = 2'd2;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  name_char;
        logic [15:0] question_type;
        logic        keep_question;
        logic [1:0]  packet_status;
        logic        last_of_item;
    } result_t;

endpackage

FILE: design/dns_query_name_extractor_unit.sv
// DNS query name extractor: 3-entry result queue after the per-byte parser.
// A byte's results are registered into the queue when the byte is accepted.
// Throughput: one byte per cycle while m_tready is high and each byte makes at
// most one result; s_tready is low while more than one result is queued.
// Reset: aresetn synchronous, active low; parser state cleared, registers at defaults.
// Depends on dqne_pkg and dns_query_name_extractor_unit_macros.svh.
`include "dns_query_name_extractor_unit_macros.svh"

module dns_query_name_extractor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // outgoing
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] name_char, [23:8] question_type,
                                   // [24] keep_question, [26:25] packet_status
    output logic        m_tlast,   // last_of_item
    output logic [1:0]  m_tuser,   // result_kind
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_LABEL,
        PH_TAIL,
        PH_DONE
    } phase_t;

    // configuration registers
    logic [15:0] wanted_class_reg, wanted_type_first_reg, wanted_type_second_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_class_reg       <= 16'd1;
            wanted_type_first_reg  <= 16'd1;
            wanted_type_second_reg <= 16'd28;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                dqne_pkg::REG_WANTED_CLASS:  wanted_class_reg       <= pwdata[15:0];
                dqne_pkg::REG_WANTED_TYPE_1: wanted_type_first_reg  <= pwdata[15:0];
                dqne_pkg::REG_WANTED_TYPE_2: wanted_type_second_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            dqne_pkg::REG_WANTED_CLASS:  prdata = {16'd0, wanted_class_reg};
            dqne_pkg::REG_WANTED_TYPE_1: prdata = {16'd0, wanted_type_first_reg};
            dqne_pkg::REG_WANTED_TYPE_2: prdata = {16'd0, wanted_type_second_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  hpos_reg, hpos_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [7:0]  lbl_reg, lbl_next;
    logic        first_reg, first_next;
    logic [1:0]  tpos_reg, tpos_next;
    logic [15:0] type_reg, type_next;
    logic [7:0]  class_reg, class_next;
    logic        wanted_reg, wanted_next;
    logic        outgoing_reg, outgoing_next;
    logic        start_reg, start_next;

    // queue
    dqne_pkg::result_t q_reg [3];
    dqne_pkg::result_t q_next [3];
    logic [1:0]        cnt_reg, cnt_next;

    logic              s_accept, pop;
    logic              has_rec;
    dqne_pkg::result_t rec, stat_rec, r0, r1;
    logic [1:0]        n_res;
    logic [15:0]       qdec;
    logic [7:0]        ldec;
    logic              keep;

    assign s_tready = (cnt_reg <= 2'd1);
    assign s_accept = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        // start of packet clears per-packet state
        phase_next    = start_reg ? PH_HEADER : phase_reg;
        hpos_next     = start_reg ? 4'd0 : hpos_reg;
        qleft_next    = start_reg ? 16'd0 : qleft_reg;
        lbl_next      = start_reg ? 8'd0 : lbl_reg;
        first_next    = start_reg ? 1'b1 : first_reg;
        tpos_next     = start_reg ? 2'd0 : tpos_reg;
        type_next     = start_reg ? 16'd0 : type_reg;
        class_next    = start_reg ? 8'd0 : class_reg;
        wanted_next   = start_reg ? 1'b0 : wanted_reg;
        outgoing_next = start_reg ? s_tuser : outgoing_reg;
        start_next    = 1'b0;

        has_rec = 1'b0;
        rec     = '0;
        qdec    = qleft_next - 16'd1;
        ldec    = lbl_next - 8'd1;
        keep    = outgoing_next && wanted_next
                  && ({class_next, s_tdata} == wanted_class_reg)
                  && (type_next == wanted_type_first_reg
                      || type_next == wanted_type_second_reg);

        unique case (phase_next)
            PH_HEADER: begin
                if (hpos_next == 4'd2) begin
                    wanted_next = !s_tdata[7] && (s_tdata[6:3] == 4'd0);
                end else if (hpos_next == 4'd4) begin
                    qleft_next = {s_tdata, 8'd0};
                end else if (hpos_next == 4'd5) begin
                    qleft_next = {qleft_next[15:8], s_tdata};
                end
                if (hpos_next == 4'(dqne_pkg::HEADER_BYTES - 1)) begin
                    hpos_next  = 4'd0;
                    first_next = 1'b1;
                    phase_next = (qleft_next == 16'd0) ? PH_DONE : PH_LENGTH;
                end else begin
                    hpos_next = hpos_next + 4'd1;
                end
            end
            PH_LENGTH: begin
                if (s_tdata == 8'd0) begin
                    phase_next = PH_TAIL;
                    tpos_next  = 2'd0;
                    first_next = 1'b1;
                end else begin
                    if (!first_next && outgoing_next) begin
                        has_rec        = 1'b1;
                        rec.result_kind = dqne_pkg::KIND_CHAR;
                        rec.name_char   = dqne_pkg::DOT_CHAR;
                    end
                    first_next = 1'b0;
                    lbl_next   = s_tdata;
                    phase_next = PH_LABEL;
                end
            end
            PH_LABEL: begin
                if (outgoing_next) begin
                    has_rec         = 1'b1;
                    rec.result_kind = dqne_pkg::KIND_CHAR;
                    rec.name_char   = s_tdata;
                end
                lbl_next = ldec;
                if (ldec == 8'd0) begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_TAIL: begin
                unique case (tpos_next)
                    2'd0: type_next  = {s_tdata, 8'd0};
                    2'd1: type_next  = {type_next[15:8], s_tdata};
                    2'd2: class_next = s_tdata;
                    default: begin
                        if (outgoing_next) begin
                            has_rec           = 1'b1;
                            rec.result_kind   = dqne_pkg::KIND_END;
                            rec.question_type = type_next;
                            rec.keep_question = keep;
                        end
                        qleft_next = qdec;
                        phase_next = (qdec == 16'd0) ? PH_DONE : PH_LENGTH;
                    end
                endcase
                tpos_next = tpos_next + 2'd1;
            end
            default: ;
        endcase

        stat_rec              = '0;
        stat_rec.result_kind  = dqne_pkg::KIND_STATUS;
        stat_rec.last_of_item = 1'b1;
        if (!outgoing_next) begin
            stat_rec.packet_status = dqne_pkg::STATUS_IGNORED;
        end else if (phase_next != PH_DONE) begin
            stat_rec.packet_status = dqne_pkg::STATUS_INCOMPATIBLE;
        end else begin
            stat_rec.packet_status = dqne_pkg::STATUS_PROCESSED;
        end
        if (s_tlast) begin
            start_next = 1'b1;
        end

        rec.last_of_item = !s_tlast;
        r1               = stat_rec;
        if (has_rec) begin
            r0    = rec;
            n_res = s_tlast ? 2'd2 : 2'd1;
        end else begin
            r0    = stat_rec;
            n_res = s_tlast ? 2'd1 : 2'd0;
        end
    end

    // queue update: shift on pop, then append this byte's results
    logic [1:0] base;

    always_comb begin
        base      = pop ? (cnt_reg - 2'd1) : cnt_reg;
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = pop ? q_reg[2] : q_reg[1];
        q_next[2] = q_reg[2];
        cnt_next  = base;
        if (s_accept) begin
            if (n_res != 2'd0) begin
                q_next[base] = r0;
            end
            if (n_res == 2'd2) begin
                q_next[base + 2'd1] = r1;
            end
            cnt_next = base + n_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= 2'd0;
            phase_reg    <= PH_HEADER;
            hpos_reg     <= 4'd0;
            qleft_reg    <= 16'd0;
            lbl_reg      <= 8'd0;
            first_reg    <= 1'b1;
            tpos_reg     <= 2'd0;
            type_reg     <= 16'd0;
            class_reg    <= 8'd0;
            wanted_reg   <= 1'b0;
            outgoing_reg <= 1'b0;
            start_reg    <= 1'b1;
        end else begin
            cnt_reg <= cnt_next;
            if (s_accept) begin
                phase_reg    <= phase_next;
                hpos_reg     <= hpos_next;
                qleft_reg    <= qleft_next;
                lbl_reg      <= lbl_next;
                first_reg    <= first_next;
                tpos_reg     <= tpos_next;
                type_reg     <= type_next;
                class_reg    <= class_next;
                wanted_reg   <= wanted_next;
                outgoing_reg <= outgoing_next;
                start_reg    <= start_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = q_reg[0].result_kind;
    assign m_tlast  = q_reg[0].last_of_item;
    assign m_tdata  = {5'd0, q_reg[0].packet_status, q_reg[0].keep_question,
                       q_reg[0].question_type, q_reg[0].name_char};

    `DQNE_ASSERT_SAME(a_status_is_last, aclk, aresetn,
        m_tvalid && (m_tuser == dqne_pkg::KIND_STATUS), m_tlast)
    `DQNE_ASSERT_NEXT(a_last_byte_restarts, aclk, aresetn,
        s_accept && s_tlast, start_reg)
    `DQNE_ASSERT_NEXT(a_single_pop_drains, aclk, aresetn,
        pop && !s_accept && (cnt_reg == 2'd1), !m_tvalid)

endmodule
